// ----- design/assert_macros.svh -----
// Assertion helpers for the design files (included by nsd_gate_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge once reset is released.
`define NSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, also during reset.
`define NSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NSD_ASSERT(label, clk, rst_n, prop, msg)
`define NSD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- design/nsd_pkg.sv -----
package nsd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int OUT_INDEX_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 32;

    localparam logic signed [15:0] START_THRESHOLD_RESET = 16'sd8000;
    localparam logic signed [15:0] REFRESH_THRESHOLD_RESET = 16'sd6000;
    localparam logic [31:0] GRACE_SAMPLES_RESET = 32'd960000;
    localparam logic [31:0] IGNORE_SAMPLES_RESET = 32'd32000;
    localparam logic signed [15:0] SILENCE = 16'sh8000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_THRESHOLD   = 2'd0,
        REG_REFRESH_THRESHOLD = 2'd1,
        REG_GRACE_SAMPLES     = 2'd2,
        REG_IGNORE_SAMPLES    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] start_threshold;
        logic signed [15:0] refresh_threshold;
        logic [31:0]        grace_samples;
        logic [31:0]        ignore_samples;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               stream_end;
    } item_t;

    typedef struct packed {
        logic [OUT_INDEX_WIDTH-1:0] segment_start;
        logic [OUT_INDEX_WIDTH-1:0] segment_end;
        logic                       end_open;
    } result_t;

endpackage

// ----- design/nsd_cfg_regs.sv -----
module nsd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nsd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [nsd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output nsd_pkg::cfg_t                        cfg
);

    nsd_pkg::cfg_t cfg_reg;
    nsd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                nsd_pkg::REG_START_THRESHOLD:   cfg_next.start_threshold = cfg_data[15:0];
                nsd_pkg::REG_REFRESH_THRESHOLD: cfg_next.refresh_threshold = cfg_data[15:0];
                nsd_pkg::REG_GRACE_SAMPLES:     cfg_next.grace_samples = cfg_data[31:0];
                nsd_pkg::REG_IGNORE_SAMPLES:    cfg_next.ignore_samples = cfg_data[31:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold <= nsd_pkg::START_THRESHOLD_RESET;
            cfg_reg.refresh_threshold <= nsd_pkg::REFRESH_THRESHOLD_RESET;
            cfg_reg.grace_samples <= nsd_pkg::GRACE_SAMPLES_RESET;
            cfg_reg.ignore_samples <= nsd_pkg::IGNORE_SAMPLES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/nsd_input_stage.sv -----
module nsd_input_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nsd_pkg::item_t in_item,
    output logic           item_valid,
    output nsd_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    nsd_pkg::item_t item_reg;

    assign in_ready = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- design/nsd_gate_core.sv -----
`include "assert_macros.svh"

module nsd_gate_core #(
    parameter int COUNT_WIDTH = nsd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  nsd_pkg::cfg_t    cfg,
    input  logic             advance,
    input  nsd_pkg::item_t   item,
    output logic             res_valid,
    output nsd_pkg::result_t res
);

    localparam int EXT_WIDTH =
        (COUNT_WIDTH > nsd_pkg::OUT_INDEX_WIDTH) ? COUNT_WIDTH : nsd_pkg::OUT_INDEX_WIDTH;

    logic                   in_noise_reg;
    logic                   in_noise_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] start_index_reg;
    logic [COUNT_WIDTH-1:0] last_loud_reg;
    logic [COUNT_WIDTH-1:0] since_loud;
    logic [EXT_WIDTH-1:0]   start_ext;
    logic [EXT_WIDTH-1:0]   last_loud_ext;
    logic                   ignored;
    logic signed [15:0]     level;
    logic                   is_start;
    logic                   is_refresh;
    logic                   grace_hit;
    logic                   open_seg;
    logic                   move_last;

    assign ignored = EXT_WIDTH'(count_reg) < EXT_WIDTH'(cfg.ignore_samples);
    assign level = ignored ? nsd_pkg::SILENCE : item.sample;
    assign is_start = level >= cfg.start_threshold;
    assign is_refresh = level >= cfg.refresh_threshold;
    assign since_loud = count_reg - last_loud_reg;
    assign grace_hit = EXT_WIDTH'(since_loud) >= EXT_WIDTH'(cfg.grace_samples);
    assign start_ext = EXT_WIDTH'(start_index_reg);
    assign last_loud_ext = EXT_WIDTH'(last_loud_reg);

    always_comb
    begin
        in_noise_next = in_noise_reg;
        count_next = count_reg;
        res_valid = 1'b0;
        open_seg = 1'b0;
        move_last = 1'b0;
        res.segment_start = start_ext[nsd_pkg::OUT_INDEX_WIDTH-1:0];
        res.segment_end = last_loud_ext[nsd_pkg::OUT_INDEX_WIDTH-1:0];
        res.end_open = 1'b0;
        if (advance)
        begin
            if (item.stream_end)
            begin
                res_valid = in_noise_reg;
                res.segment_end = '0;
                res.end_open = 1'b1;
                in_noise_next = 1'b0;
                count_next = '0;
            end
            else
            begin
                if (in_noise_reg)
                begin
                    if (is_refresh)
                    begin
                        move_last = 1'b1;
                    end
                    else if (grace_hit)
                    begin
                        in_noise_next = 1'b0;
                        res_valid = 1'b1;
                    end
                end
                else if (is_start)
                begin
                    in_noise_next = 1'b1;
                    open_seg = 1'b1;
                end
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_noise_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            in_noise_reg <= in_noise_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (open_seg)
        begin
            start_index_reg <= count_reg;
        end
        if (open_seg || move_last)
        begin
            last_loud_reg <= count_reg;
        end
    end

    `NSD_ASSERT(a_flush_form, clk, rst_n, advance && item.stream_end && in_noise_reg |-> res_valid && res.end_open && (res.segment_end == '0), "End of stream with an open segment must give an open-ended result.")
    `NSD_ASSERT(a_flush_clears, clk, rst_n, advance && item.stream_end |=> (count_reg == '0) && !in_noise_reg, "End of stream must clear the counter and the gate.")
    `NSD_ASSERT(a_quiet_silent, clk, rst_n, !in_noise_reg |-> !res_valid, "No result may come while the gate is closed.")
    `NSD_ASSERT(a_count_step, clk, rst_n, advance && !item.stream_end |=> (count_reg == $past(count_reg) + 1'b1) || (count_reg == '1), "The sample counter must step by one or saturate.")

endmodule

// ----- design/nsd_output_stage.sv -----
module nsd_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  nsd_pkg::result_t res,
    output logic             load_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output nsd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    nsd_pkg::result_t res_reg;

    assign load_ok = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- design/noise_segment_detector.sv -----
// Loud-segment detector for a stream of signed 16-bit audio samples. Each sample transfer
// gets an index from a saturating counter; a segment opens on a sample at or above
// start_threshold and closes, giving its start and last-loud index, after grace_samples
// samples with none at or above refresh_threshold. A transfer with s_tlast set ends the
// stream: an open segment is reported with m_tuser set and the counter restarts at zero.
// One item is taken per clock cycle while the result side does not stall. Each item is held
// in the input register, and its result is loaded into the result register as the item
// leaves it. The gate state is updated in the single step between the two registers. A
// stall on the result side holds the input side only once both the result register and
// the input register are full. Configuration writes are taken in any cycle and should be
// made while the stream is idle.
module noise_segment_detector #(
    parameter int COUNT_WIDTH = nsd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // sample
    input  logic                                s_tlast,   // stream_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,   // segment_end in [63:32], segment_start in [31:0]
    output logic                                m_tuser,   // end_open
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nsd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [nsd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    nsd_pkg::cfg_t    cfg;
    nsd_pkg::item_t   in_item;
    nsd_pkg::item_t   item;
    nsd_pkg::result_t res;
    nsd_pkg::result_t out_res;
    logic             item_valid;
    logic             load_ok;
    logic             advance;
    logic             res_valid;

    assign in_item.sample = s_tdata;
    assign in_item.stream_end = s_tlast;
    assign advance = item_valid && load_ok;
    assign m_tdata = {out_res.segment_end, out_res.segment_start};
    assign m_tuser = out_res.end_open;

    nsd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nsd_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (advance)
    );

    nsd_gate_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_gate_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    nsd_output_stage u_output_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

endmodule
